// ===== hw/rtl/tilt_axis_conditioner_core_macros.svh =====
// Assertion macros for the tilt axis conditioner.
// Used by the RTL files that carry concurrent checks; no dependencies.
`ifndef TILT_AXIS_CONDITIONER_CORE_MACROS_SVH
`define TILT_AXIS_CONDITIONER_CORE_MACROS_SVH

// same-cycle implication
`define TAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define TAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== hw/rtl/tac_pkg.sv =====
// Shared types and constants of the tilt axis conditioner.
// No dependencies.
package tac_pkg;

  localparam int unsigned QBITS = 15;
  localparam int unsigned CNT_W = $clog2(QBITS + 1);
  localparam logic [QBITS-1:0] QMAX = 15'd16384;

  typedef enum logic [2:0] {
    CFG_FULL_SCALE = 3'd0,
    CFG_DEADZONE   = 3'd1,
    CFG_GAIN       = 3'd2,
    CFG_ALPHA      = 3'd3,
    CFG_JUMP_LEVEL = 3'd4,
    CFG_DOWN_LEVEL = 3'd5,
    CFG_USE_Y      = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QBITS-1:0] quot;
  } div_res_t;

endpackage

// ===== hw/rtl/tac_divider.sv =====
// Radix-2 restoring divider: (mag * 2^14) / div, one quotient bit per cycle.
// Flags overflow when the quotient would not fit QBITS bits. Uses tac_pkg.
module tac_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [16:0]       mag_i,
  input  logic [15:0]       div_i,
  output tac_pkg::div_res_t res_o
);
  import tac_pkg::*;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [15:0]      r_q, d_q;
  logic [QBITS-1:0] bits_q, quo_q;
  logic             ovf_q;
  logic [16:0]      trial;
  logic             ge;

  assign trial = {r_q, bits_q[QBITS-1]};
  assign ge    = trial >= {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QBITS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= mag_i[16:1];
      bits_q <= {mag_i[0], {(QBITS-1){1'b0}}};
      d_q    <= div_i;
      quo_q  <= '0;
      ovf_q  <= mag_i >= {div_i, 1'b0};
    end else if (busy_q) begin
      r_q    <= ge ? 16'(trial - {1'b0, d_q}) : trial[15:0];
      bits_q <= {bits_q[QBITS-2:0], 1'b0};
      quo_q  <= {quo_q[QBITS-2:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quo_q;

endmodule

// ===== hw/rtl/tac_mul.sv =====
// Shared unsigned multiplier with registered product.
// No dependencies.
module tac_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] a_i,
  input  logic [15:0] b_i,
  output logic [32:0] p_o
);

  logic [32:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 33'(a_i) * 33'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/tilt_axis_conditioner_core.sv =====
// Top level of the tilt axis conditioner: config registers, sequencer, output register.
// Depends on tac_pkg, tac_divider, tac_mul and the assertion macro header.
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | raw_x_i, raw_y_i, player_dead_i, exit_pending_i
//  out     | out_valid_o/out_stall_i | move_axis_o, jump/down press/release, first_input_o
//  cfg     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// An item runs from acceptance to the output register through START, DIV, MUL and GAIN
// for each axis, then SMUL and SMOOTH when smoothing is on; divider and multiplier are shared.
// Suppressed items are accepted while idle and give no result.
// Reset is asynchronous and active low; no clearing pass.
// A waiting result holds the sequencer in its final step; no new item is taken meanwhile.
`include "tilt_axis_conditioner_core_macros.svh"

module tilt_axis_conditioner_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_x_i,
  input  logic signed [15:0] raw_y_i,
  input  logic               player_dead_i,
  input  logic               exit_pending_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] move_axis_o,
  output logic               jump_press_o,
  output logic               jump_release_o,
  output logic               down_press_o,
  output logic               down_release_o,
  output logic               first_input_o
);
  import tac_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_GAIN   = 8'b0001_0000,
    S_SMUL   = 8'b0010_0000,
    S_SMOOTH = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]        full_scale_q, gain_q;
  logic [14:0]        deadzone_q, alpha_q;
  logic signed [15:0] jump_level_q, down_level_q;
  logic               use_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= 16'd16384;
      deadzone_q   <= 15'd1638;
      gain_q       <= 16'd4096;
      alpha_q      <= 15'd0;
      jump_level_q <= 16'sd8192;
      down_level_q <= -16'sd8192;
      use_y_q      <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FULL_SCALE: full_scale_q <= cfg_data_i;
        CFG_DEADZONE:   deadzone_q   <= cfg_data_i[14:0];
        CFG_GAIN:       gain_q       <= cfg_data_i;
        CFG_ALPHA:      alpha_q      <= cfg_data_i[14:0];
        CFG_JUMP_LEVEL: jump_level_q <= cfg_data_i;
        CFG_DOWN_LEVEL: down_level_q <= cfg_data_i;
        CFG_USE_Y:      use_y_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic               axis_q, axis_d;
  logic signed [15:0] rx_q, ry_q;
  logic               neg_q;
  logic [QBITS-1:0]   mq_q;
  logic signed [15:0] x_q, y_q, s_q, mx_q;
  logic               jh_q, dh_q;
  logic               accept, suppress, out_load;

  logic signed [15:0] raw_sel;
  logic [16:0]        raw_mag;
  logic [15:0]        fs_eff;
  div_res_t           div_res;
  logic [QBITS-1:0]   qm, mq;

  logic [16:0]        mul_a;
  logic [15:0]        mul_b;
  logic [32:0]        prod;
  logic [QBITS-1:0]   gm, alpha_eff;
  logic signed [15:0] gs;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [18:0]        dm;
  logic signed [19:0] delta, sum;
  logic signed [15:0] s_new;
  logic               want_jump, want_down;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign suppress   = player_dead_i || exit_pending_i;
  assign out_load   = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);

  assign raw_sel = axis_q ? ry_q : rx_q;
  assign raw_mag = raw_sel[15] ? 17'(-{raw_sel[15], raw_sel}) : 17'({raw_sel[15], raw_sel});
  assign fs_eff  = (full_scale_q == '0) ? 16'd1 : full_scale_q;

  tac_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_START),
    .mag_i  (raw_mag),
    .div_i  (fs_eff),
    .res_o  (div_res)
  );

  assign qm = (div_res.ovf || div_res.quot > QMAX) ? QMAX : div_res.quot;
  assign mq = (qm < deadzone_q) ? '0 : qm;

  assign alpha_eff = (alpha_q > QMAX) ? QMAX : alpha_q;
  assign diff      = 17'(x_q) - 17'(s_q);
  assign diff_mag  = diff[16] ? 17'(-diff) : 17'(diff);

  always_comb begin
    if (state_q == S_SMUL) begin
      mul_a = diff_mag;
      mul_b = {1'b0, alpha_eff};
    end else begin
      mul_a = {2'b0, mq_q};
      mul_b = gain_q;
    end
  end

  tac_mul u_mul (
    .clk_i(clk_i),
    .en_i (state_q == S_MUL || state_q == S_SMUL),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign gm = (prod[32:12] > 21'(QMAX)) ? QMAX : prod[26:12];
  assign gs = neg_q ? 16'(-{1'b0, gm}) : 16'({1'b0, gm});

  assign dm    = prod[32:14];
  assign delta = diff[16] ? 20'(-{1'b0, dm}) : 20'({1'b0, dm});
  assign sum   = 20'(s_q) + delta;
  always_comb begin
    if (sum > 20'sd16384) begin
      s_new = 16'sd16384;
    end else if (sum < -20'sd16384) begin
      s_new = -16'sd16384;
    end else begin
      s_new = sum[15:0];
    end
  end

  assign want_jump = y_q >= jump_level_q;
  assign want_down = y_q <= down_level_q;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      S_IDLE:   if (accept && !suppress) begin
        state_d = S_START;
        axis_d  = 1'b0;
      end
      S_START:  state_d = S_DIV;
      S_DIV:    if (div_res.done) state_d = S_MUL;
      S_MUL:    state_d = S_GAIN;
      S_GAIN:   priority if (!axis_q) begin
        state_d = S_START;
        axis_d  = 1'b1;
      end else if (alpha_q != '0) begin
        state_d = S_SMUL;
      end else begin
        state_d = S_OUT;
      end
      S_SMUL:   state_d = S_SMOOTH;
      S_SMOOTH: state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      s_q         <= '0;
      jh_q        <= 1'b0;
      dh_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (state_q == S_SMOOTH) begin
        s_q <= s_new;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
        if (use_y_q) begin
          jh_q <= want_jump;
          dh_q <= want_down;
        end
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_q <= raw_x_i;
      ry_q <= raw_y_i;
    end
    if (state_q == S_START) begin
      neg_q <= raw_sel[15];
    end
    if (state_q == S_DIV && div_res.done) begin
      mq_q <= mq;
    end
    if (state_q == S_GAIN) begin
      if (axis_q) begin
        y_q <= gs;
      end else begin
        x_q  <= gs;
        mx_q <= gs;
      end
    end
    if (state_q == S_SMOOTH) begin
      mx_q <= s_new;
    end
    if (out_load) begin
      move_axis_o    <= mx_q;
      jump_press_o   <= use_y_q && want_jump && !jh_q;
      jump_release_o <= use_y_q && !want_jump && jh_q;
      down_press_o   <= use_y_q && want_down && !dh_q;
      down_release_o <= use_y_q && !want_down && dh_q;
      first_input_o  <= use_y_q && ((want_jump && !jh_q) || (want_down && !dh_q));
    end
  end

  `TAC_ASSERT_NEXT(a_start_after_accept, clk_i, rst_ni,
    accept && !suppress, state_q == S_START)
  `TAC_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni,
    div_res.done, state_q == S_DIV)
  `TAC_ASSERT_IMPL(a_first_input_or, clk_i, rst_ni,
    out_valid_o, first_input_o == (jump_press_o || down_press_o))
  `TAC_ASSERT_IMPL(a_jump_one_pulse, clk_i, rst_ni,
    out_valid_o, !(jump_press_o && jump_release_o))
  `TAC_ASSERT_IMPL(a_move_range, clk_i, rst_ni,
    out_valid_o, move_axis_o <= 16'sd16384 && move_axis_o >= -16'sd16384)

endmodule

// ===== verif/tac_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the tilt axis conditioner: tracks register writes, predicts each result
// from the accepted samples and compares it with the output channel. Depends on tac_pkg.
module tac_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] raw_x_i,
  input  logic signed [15:0] raw_y_i,
  input  logic               player_dead_i,
  input  logic               exit_pending_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] move_axis_i,
  input  logic               jump_press_i,
  input  logic               jump_release_i,
  input  logic               down_press_i,
  input  logic               down_release_i,
  input  logic               first_input_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        outstanding_o
);
  import tac_pkg::*;

  localparam longint UNIT = 16384;

  typedef struct packed {
    logic signed [15:0] move_axis;
    logic               jump_press;
    logic               jump_release;
    logic               down_press;
    logic               down_release;
    logic               first_input;
  } tilt_result_t;

  tilt_result_t       expected_q[$];
  int unsigned        mismatches;

  logic [15:0]        full_scale_r;
  logic [14:0]        deadzone_r;
  logic [15:0]        gain_r;
  logic [14:0]        alpha_r;
  logic signed [15:0] jump_level_r;
  logic signed [15:0] down_level_r;
  logic               use_y_r;

  logic signed [15:0] smooth_x;
  logic               jump_held;
  logic               down_held;

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  // arithmetic shift that rounds toward zero
  function automatic longint trunc_shift(input longint v, input int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic logic signed [15:0] condition_axis(input logic signed [15:0] raw);
    longint fs, q, mag;
    fs = (full_scale_r == '0) ? 1 : longint'({1'b0, full_scale_r});
    q = clamp_unit((longint'(raw) * UNIT) / fs);
    mag = (q < 0) ? -q : q;
    if (mag < longint'({1'b0, deadzone_r})) q = 0;
    q = clamp_unit(trunc_shift(q * longint'({1'b0, gain_r}), 12));
    return 16'(q);
  endfunction

  task automatic predict_sample(input logic signed [15:0] rx, input logic signed [15:0] ry);
    logic signed [15:0] cx, cy;
    logic               want_jump, want_down;
    longint             a, d;
    tilt_result_t       r;
    cx = condition_axis(rx);
    cy = condition_axis(ry);
    r = '0;
    r.move_axis = cx;
    if (alpha_r != '0) begin
      a = (alpha_r > QMAX) ? UNIT : longint'({1'b0, alpha_r});
      d = longint'(cx) - longint'(smooth_x);
      smooth_x = 16'(clamp_unit(longint'(smooth_x) + trunc_shift(d * a, 14)));
      r.move_axis = smooth_x;
    end
    if (use_y_r) begin
      want_jump = (cy >= jump_level_r);
      want_down = (cy <= down_level_r);
      if (want_jump && !jump_held) begin
        jump_held = 1'b1;
        r.jump_press = 1'b1;
      end else if (!want_jump && jump_held) begin
        jump_held = 1'b0;
        r.jump_release = 1'b1;
      end
      if (want_down && !down_held) begin
        down_held = 1'b1;
        r.down_press = 1'b1;
      end else if (!want_down && down_held) begin
        down_held = 1'b0;
        r.down_release = 1'b1;
      end
    end
    r.first_input = r.jump_press | r.down_press;
    expected_q.push_back(r);
  endtask

  task automatic compare_field(input string field, input int want, input int got, input bit bad);
    if (bad) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    tilt_result_t e;
    if (expected_q.size() == 0) begin
      compare_field("unexpected item, move_axis", 0, move_axis_i, 1'b1);
    end else begin
      e = expected_q.pop_front();
      compare_field("move_axis", e.move_axis, move_axis_i, move_axis_i !== e.move_axis);
      compare_field("jump_press", e.jump_press, jump_press_i,
                    jump_press_i !== e.jump_press);
      compare_field("jump_release", e.jump_release, jump_release_i,
                    jump_release_i !== e.jump_release);
      compare_field("down_press", e.down_press, down_press_i,
                    down_press_i !== e.down_press);
      compare_field("down_release", e.down_release, down_release_i,
                    down_release_i !== e.down_release);
      compare_field("first_input", e.first_input, first_input_i,
                    first_input_i !== e.first_input);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_r = 16'd16384;
      deadzone_r = 15'd1638;
      gain_r = 16'd4096;
      alpha_r = '0;
      jump_level_r = 16'sd8192;
      down_level_r = -16'sd8192;
      use_y_r = 1'b1;
      smooth_x = '0;
      jump_held = 1'b0;
      down_held = 1'b0;
      expected_q.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_FULL_SCALE: full_scale_r = cfg_data_i;
          CFG_DEADZONE:   deadzone_r = cfg_data_i[14:0];
          CFG_GAIN:       gain_r = cfg_data_i;
          CFG_ALPHA:      alpha_r = cfg_data_i[14:0];
          CFG_JUMP_LEVEL: jump_level_r = cfg_data_i;
          CFG_DOWN_LEVEL: down_level_r = cfg_data_i;
          CFG_USE_Y:      use_y_r = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i === 1'b1 && out_stall_i == 1'b0) begin
        check_result();
      end
      if (in_valid_i && in_stall_i === 1'b0 && !player_dead_i && !exit_pending_i) begin
        predict_sample(raw_x_i, raw_y_i);
      end
      mismatch_count_o <= mismatches;
      outstanding_o <= expected_q.size();
    end
  end

endmodule

// ===== verif/tb_tilt_axis_conditioner_core.sv =====
`timescale 1ns / 100ps
// Testbench top for tilt_axis_conditioner_core: drives samples, register settings and
// output stalls; tac_result_checker predicts and compares. Depends on tac_pkg.
module tb_tilt_axis_conditioner_core;
  import tac_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          PHASES = 10;
  localparam int          ITEMS_PER_PHASE = 103;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_index_e         cfg_index = CFG_FULL_SCALE;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] raw_x = '0;
  logic signed [15:0] raw_y = '0;
  logic               player_dead = 1'b0;
  logic               exit_pending = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] move_axis;
  logic               jump_press, jump_release, down_press, down_release, first_input;
  int unsigned        mismatch_count, outstanding;

  bit                 quiet = 1'b0;
  int                 stim_fs = 16384;

  tilt_axis_conditioner_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .raw_x_i        (raw_x),
    .raw_y_i        (raw_y),
    .player_dead_i  (player_dead),
    .exit_pending_i (exit_pending),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .move_axis_o    (move_axis),
    .jump_press_o   (jump_press),
    .jump_release_o (jump_release),
    .down_press_o   (down_press),
    .down_release_o (down_release),
    .first_input_o  (first_input)
  );

  tac_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .raw_x_i          (raw_x),
    .raw_y_i          (raw_y),
    .player_dead_i    (player_dead),
    .exit_pending_i   (exit_pending),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .move_axis_i      (move_axis),
    .jump_press_i     (jump_press),
    .jump_release_i   (jump_release),
    .down_press_i     (down_press),
    .down_release_i   (down_release),
    .first_input_i    (first_input),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
        repeat (idle_len() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** tilt_axis_conditioner_core: FAILED **");
    $finish;
  end

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic dead, input logic ex);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    raw_x <= x;
    raw_y <= y;
    player_dead <= dead;
    exit_pending <= ex;
    do @(posedge clk_i); while (in_stall !== 1'b0);
  endtask

  // wait for every result, then for the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] fs, input logic [15:0] dz,
                              input logic [15:0] gn, input logic [15:0] al,
                              input logic [15:0] jl, input logic [15:0] dl, input logic uy);
    logic [15:0] vals[7];
    vals = '{fs, dz, gn, al, jl, dl, {15'd0, uy}};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_index_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    stim_fs = fs;
  endtask

  function automatic logic signed [15:0] pick_raw(input int fs);
    int     r, fse;
    longint v;
    fse = (fs == 0) ? 1 : fs;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom);
    if (r < 90) begin
      // spread around the Q1.14 range so Y crosses the levels
      v = (longint'($urandom_range(0, 40000)) - 20000) * fse / 16384;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    end
    case ($urandom_range(0, 4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  task automatic random_regs();
    logic [15:0] fs, dz, gn, al;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 5) fs = 16'($urandom_range(32769, 65535));
    else if (r < 60) fs = 16'($urandom_range(256, 20000));
    else fs = 16'($urandom_range(1, 32768));
    dz = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 32767))
                                     : 16'($urandom_range(0, 4000));
    gn = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(2048, 12288));
    r = $urandom_range(0, 99);
    if (r < 30) al = '0;
    else if (r < 90) al = 16'($urandom_range(1, 16384));
    else al = 16'($urandom_range(16385, 32767));
    program_regs(fs, dz, gn, al, 16'($urandom_range(0, 32768) - 16384),
                 16'($urandom_range(0, 32768) - 16384), $urandom_range(0, 99) < 80);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: extremes, deadzone edges, level crossings, suppression
    send_sample(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_sample(16'sd32767, 16'sd32767, 1'b0, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
    send_sample(16'sd100, 16'sd0, 1'b0, 1'b1);
    send_sample(16'sd100, 16'sd32767, 1'b1, 1'b1);
    send_sample(16'sd1637, 16'sd1638, 1'b0, 1'b0);
    send_sample(-16'sd1638, -16'sd1637, 1'b0, 1'b0);
    send_sample(16'sd16384, 16'sd8192, 1'b0, 1'b0);
    send_sample(16'sd16384, 16'sd8191, 1'b0, 1'b0);
    send_sample(-16'sd16384, -16'sd8192, 1'b0, 1'b0);
    send_sample(-16'sd1, 16'sd1, 1'b0, 1'b0);
    send_sample(16'sd0, -16'sd8191, 1'b0, 1'b0);
    send_sample(16'sd12345, -16'sd32768, 1'b0, 1'b0);
    send_sample(-16'sd12345, 16'sd32767, 1'b0, 1'b0);
    settle();

    // zero full scale, no deadzone, max gain
    program_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'sd16384, -16'sd16384, 1'b1);
    send_sample(16'sd1, -16'sd1, 1'b0, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0, 1'b0);
    settle();

    // full smoothing, both levels crossed so jump and down hold together
    program_regs(16'd32768, 16'd0, 16'd4096, 16'd16384, -16'sd16384, 16'sd16384, 1'b1);
    send_sample(16'sd32767, 16'sd0, 1'b0, 1'b0);
    send_sample(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
    send_sample(16'sd5, -16'sd32768, 1'b0, 1'b0);
    settle();

    // alpha above one, deadzone above one, Y mapping off
    program_regs(16'd1000, 16'd32767, 16'd4096, 16'd32767, 16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd32767, 16'sd32767, 1'b0, 1'b0);
    send_sample(-16'sd500, -16'sd32768, 1'b0, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 3 || p == 7);
      case (p)
        0: program_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'sd16384, -16'sd16384, 1'b1);
        1: program_regs(16'd32768, 16'd16384, 16'd0, 16'd16384, -16'sd16384, 16'sd16384,
                        1'b1);
        2: program_regs(16'd16384, 16'd1638, 16'd8192, 16'd1, 16'sd8192, -16'sd8192, 1'b1);
        3: program_regs(16'd4096, 16'd200, 16'd4096, 16'd3000, 16'sd0, 16'sd0, 1'b1);
        default: random_regs();
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_sample(pick_raw(stim_fs), pick_raw(stim_fs),
                    $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 6);
      end
      settle();
    end
    quiet = 1'b0;

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** tilt_axis_conditioner_core: PASSED **");
    end else begin
      $display("** tilt_axis_conditioner_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tac_pkg.sv
hw/rtl/tac_divider.sv
hw/rtl/tac_mul.sv
hw/rtl/tilt_axis_conditioner_core.sv
verif/tac_result_checker.sv
verif/tb_tilt_axis_conditioner_core.sv
